[design/pps_pkg.sv]
// ----------------------------------------------------------------------------
// pps_pkg: shared constants, command codes and helpers
// Sizes, command kinds and the index and playhead arithmetic of the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package pps_pkg;

  localparam int COLUMNS = 4;
  localparam int CELLS   = 64;

  localparam int COL_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int IDX_W  = $clog2(CELLS);
  localparam int LEN_W  = $clog2(CELLS + 1);
  localparam int ADDR_W = COL_W + IDX_W;
  localparam int CMP_W  = IDX_W + 3;
  localparam int DUR_W  = 15;

  localparam logic [4:0] K_RDVAL   = 5'd0;
  localparam logic [4:0] K_WRVAL   = 5'd1;
  localparam logic [4:0] K_RDHERE  = 5'd2;
  localparam logic [4:0] K_WRHERE  = 5'd3;
  localparam logic [4:0] K_RDPH    = 5'd4;
  localparam logic [4:0] K_SETPH   = 5'd5;
  localparam logic [4:0] K_RDLEN   = 5'd6;
  localparam logic [4:0] K_SETLEN  = 5'd7;
  localparam logic [4:0] K_RDWRAP  = 5'd8;
  localparam logic [4:0] K_SETWRAP = 5'd9;
  localparam logic [4:0] K_RDSTART = 5'd10;
  localparam logic [4:0] K_SETSTART= 5'd11;
  localparam logic [4:0] K_RDEND   = 5'd12;
  localparam logic [4:0] K_SETEND  = 5'd13;
  localparam logic [4:0] K_NEXT    = 5'd14;
  localparam logic [4:0] K_NEXTWR  = 5'd15;
  localparam logic [4:0] K_NEXTALL = 5'd16;
  localparam logic [4:0] K_RDDUR   = 5'd17;
  localparam logic [4:0] K_WRDUR   = 5'd18;
  localparam logic [4:0] K_RDDURH  = 5'd19;
  localparam logic [4:0] K_WRDURH  = 5'd20;
  localparam logic [4:0] K_STEP    = 5'd21;
  localparam logic [4:0] K_RDFLAG  = 5'd22;
  localparam logic [4:0] K_STEPFLAG= 5'd23;
  localparam logic [4:0] K_STEPALL = 5'd24;

  // negative index counts back from the length, then clamp into the table
  function automatic logic [IDX_W-1:0] norm_idx(logic signed [15:0] i,
                                                logic [LEN_W-1:0] len);
    logic signed [17:0] t;
    t = (i < 0) ? (18'(i) + 18'(signed'({1'b0, len}))) : 18'(i);
    if (t < 0) begin
      return '0;
    end else if (t >= 18'(CELLS)) begin
      return IDX_W'(CELLS - 1);
    end
    return t[IDX_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] adv_ph(logic [IDX_W-1:0] ph,
                                              logic [LEN_W-1:0] len,
                                              logic [IDX_W-1:0] start,
                                              logic [IDX_W-1:0] last,
                                              logic wrap);
    logic [CMP_W-1:0] p;
    if ((CMP_W'(ph) + CMP_W'(1) == CMP_W'(len)) || (ph == last)) begin
      p = wrap ? CMP_W'(start) : CMP_W'(ph);
    end else begin
      p = CMP_W'(ph) + CMP_W'(1);
    end
    if ((p > CMP_W'(len)) || (p >= CMP_W'(CELLS))) begin
      p = '0;
    end
    return p[IDX_W-1:0];
  endfunction

endpackage

`default_nettype wire

[design/pps_cell_mem.sv]
// ----------------------------------------------------------------------------
// pps_cell_mem: cell value and duration store
// Two arrays with separate write and read addresses and registered reads;
// per-slot valid bits give value 0 and duration 1 for slots never written.
// ----------------------------------------------------------------------------
`default_nettype none

module pps_cell_mem (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic [pps_pkg::ADDR_W-1:0] waddr_i,
  input  wire logic                       val_we_i,
  input  wire logic [15:0]                val_wd_i,
  input  wire logic                       dur_we_i,
  input  wire logic [pps_pkg::DUR_W-1:0]  dur_wd_i,
  input  wire logic [pps_pkg::ADDR_W-1:0] raddr_i,
  output logic [15:0]                     val_rd_o,
  output logic [pps_pkg::DUR_W-1:0]       dur_rd_o
);

  localparam int DEPTH = 2 ** pps_pkg::ADDR_W;

  logic [15:0]               val_mem [DEPTH];
  logic [pps_pkg::DUR_W-1:0] dur_mem [DEPTH];
  logic [DEPTH-1:0]          vld_q;
  logic [15:0]               val_rd_q;
  logic [pps_pkg::DUR_W-1:0] dur_rd_q;
  logic                      vld_rd_q;
  logic                      val_wr, dur_wr;
  logic                      slot_vld;

  // first write to a slot also puts the reset value into the other array
  assign slot_vld = vld_q[waddr_i];
  assign val_wr   = val_we_i || (dur_we_i && !slot_vld);
  assign dur_wr   = dur_we_i || (val_we_i && !slot_vld);

  always_ff @(posedge clk_i) begin
    if (val_wr) begin
      val_mem[waddr_i] <= val_we_i ? val_wd_i : 16'd0;
    end
    if (dur_wr) begin
      dur_mem[waddr_i] <= dur_we_i ? dur_wd_i : pps_pkg::DUR_W'(1);
    end
    val_rd_q <= val_mem[raddr_i];
    dur_rd_q <= dur_mem[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      vld_rd_q <= 1'b0;
    end else begin
      if (val_we_i || dur_we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      vld_rd_q <= vld_q[raddr_i];
    end
  end

  assign val_rd_o = vld_rd_q ? val_rd_q : 16'd0;
  assign dur_rd_o = vld_rd_q ? dur_rd_q : pps_pkg::DUR_W'(1);

endmodule

`default_nettype wire

[design/pattern_playhead_sequencer.sv]
// Path from accept to tvalid: EXEC, PUT for setting, playhead and flag reads;
//   EXEC, MEMRD, PUT for cell and duration reads; EXEC, STEP, PUT for step-then-flag;
//   EXEC, EXEC, MEMRD, PUT for advance-then-read; EXEC, STEP, EXEC, MEMRD, PUT for
//   step-then-read. One word at a time, tready low while busy; sweeps go by column.
// Reset: async, active low; all columns return to length 0, start 0, end at
//   the last cell, wrap on; cells read as value 0, duration 1 until written.
// ----------------------------------------------------------------------------
// pattern_playhead_sequencer: multi-column step sequencer
// Command-driven sequencer over per-column cell tables with stage durations.
// ----------------------------------------------------------------------------
`default_nettype none

module pattern_playhead_sequencer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,  // column, cell_index, data_word
  input  wire logic [4:0]  s_axis_tuser,  // kind
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata   // read_word
);

  localparam int COLUMNS = pps_pkg::COLUMNS;
  localparam int COL_W   = pps_pkg::COL_W;
  localparam int IDX_W   = pps_pkg::IDX_W;
  localparam int LEN_W   = pps_pkg::LEN_W;
  localparam int DUR_W   = pps_pkg::DUR_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_EXEC  = 3'd1;
  localparam logic [2:0] ST_MEMRD = 3'd2;
  localparam logic [2:0] ST_STEP  = 3'd3;
  localparam logic [2:0] ST_PUT   = 3'd4;

  logic [2:0]        st_q;
  logic [4:0]        kind_q;
  logic [COL_W-1:0]  col_q;
  logic signed [15:0] idx_q, data_q;
  logic [15:0]       res_q, out_q;
  logic              out_vld_q;

  logic [IDX_W-1:0]  ph_q    [COLUMNS];
  logic [DUR_W-1:0]  dwell_q [COLUMNS];
  logic              flag_q  [COLUMNS];
  logic [LEN_W-1:0]  len_q   [COLUMNS];
  logic [IDX_W-1:0]  start_q [COLUMNS];
  logic [IDX_W-1:0]  end_q   [COLUMNS];
  logic              wrap_q  [COLUMNS];

  logic               s_acc;
  logic signed [15:0] in_col, in_idx, in_data;
  logic [COL_W-1:0]   in_col_c;
  logic [IDX_W-1:0]   cur_ph, nidx, nxt_ph;
  logic [LEN_W-1:0]   cur_len;
  logic [DUR_W-1:0]   cur_dwell;
  logic               use_idx, last_col;
  logic [pps_pkg::ADDR_W-1:0] addr;
  logic               val_we, dur_we;
  logic [DUR_W-1:0]   dur_wd;
  logic [15:0]        val_rd;
  logic [DUR_W-1:0]   dur_rd;

  assign in_col  = s_axis_tdata[15:0];
  assign in_idx  = s_axis_tdata[31:16];
  assign in_data = s_axis_tdata[47:32];
  assign s_axis_tready = (st_q == ST_IDLE);
  assign s_acc = s_axis_tvalid && s_axis_tready;

  always_comb begin
    if (in_col < 0) begin
      in_col_c = '0;
    end else if (in_col >= 16'(COLUMNS)) begin
      in_col_c = COL_W'(COLUMNS - 1);
    end else begin
      in_col_c = in_col[COL_W-1:0];
    end
  end

  assign cur_ph    = ph_q[col_q];
  assign cur_len   = len_q[col_q];
  assign cur_dwell = dwell_q[col_q];
  assign nidx      = pps_pkg::norm_idx(idx_q, cur_len);
  assign nxt_ph    = pps_pkg::adv_ph(cur_ph, cur_len, start_q[col_q], end_q[col_q],
                                     wrap_q[col_q]);
  assign last_col  = (col_q == COL_W'(COLUMNS - 1));

  assign use_idx = (kind_q == pps_pkg::K_RDVAL) || (kind_q == pps_pkg::K_WRVAL) ||
                   (kind_q == pps_pkg::K_RDDUR) || (kind_q == pps_pkg::K_WRDUR);
  assign addr    = {col_q, use_idx ? nidx : cur_ph};

  assign val_we = (st_q == ST_EXEC) &&
                  ((kind_q == pps_pkg::K_WRVAL) || (kind_q == pps_pkg::K_WRHERE));
  assign dur_we = (st_q == ST_EXEC) &&
                  ((kind_q == pps_pkg::K_WRDUR) || (kind_q == pps_pkg::K_WRDURH));
  assign dur_wd = (data_q < 16'sd1) ? DUR_W'(1) : data_q[DUR_W-1:0];

  pps_cell_mem u_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .waddr_i  (addr),
    .val_we_i (val_we),
    .val_wd_i (data_q),
    .dur_we_i (dur_we),
    .dur_wd_i (dur_wd),
    .raddr_i  (addr),
    .val_rd_o (val_rd),
    .dur_rd_o (dur_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_IDLE;
      kind_q    <= '0;
      col_q     <= '0;
      idx_q     <= '0;
      data_q    <= '0;
      res_q     <= '0;
      out_q     <= '0;
      out_vld_q <= 1'b0;
      for (int k = 0; k < COLUMNS; k++) begin
        ph_q[k]    <= '0;
        dwell_q[k] <= '0;
        flag_q[k]  <= 1'b0;
        len_q[k]   <= '0;
        start_q[k] <= '0;
        end_q[k]   <= IDX_W'(pps_pkg::CELLS - 1);
        wrap_q[k]  <= 1'b1;
      end
    end else begin
      // in ST_PUT the output register is reloaded instead
      if (out_vld_q && m_axis_tready && (st_q != ST_PUT)) begin
        out_vld_q <= 1'b0;
      end
      case (st_q)
        ST_IDLE: begin
          if (s_acc) begin
            kind_q <= s_axis_tuser;
            idx_q  <= in_idx;
            data_q <= in_data;
            col_q  <= ((s_axis_tuser == pps_pkg::K_NEXTALL) ||
                       (s_axis_tuser == pps_pkg::K_STEPALL)) ? '0 : in_col_c;
            st_q   <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          case (kind_q)
            pps_pkg::K_RDVAL, pps_pkg::K_RDHERE,
            pps_pkg::K_RDDUR, pps_pkg::K_RDDURH: st_q <= ST_MEMRD;
            pps_pkg::K_RDPH: begin
              res_q <= 16'(cur_ph);
              st_q  <= ST_PUT;
            end
            pps_pkg::K_SETPH: begin
              if (cur_len == '0) begin
                ph_q[col_q] <= '0;
              end else if (LEN_W'(nidx) >= cur_len) begin
                ph_q[col_q] <= IDX_W'(cur_len - LEN_W'(1));
              end else begin
                ph_q[col_q] <= nidx;
              end
              dwell_q[col_q] <= '0;
              st_q           <= ST_IDLE;
            end
            pps_pkg::K_RDLEN: begin
              res_q <= 16'(cur_len);
              st_q  <= ST_PUT;
            end
            pps_pkg::K_SETLEN: begin
              if (data_q < 0) begin
                len_q[col_q] <= '0;
              end else if (data_q > 16'(pps_pkg::CELLS)) begin
                len_q[col_q] <= LEN_W'(pps_pkg::CELLS);
              end else begin
                len_q[col_q] <= data_q[LEN_W-1:0];
              end
              st_q <= ST_IDLE;
            end
            pps_pkg::K_RDWRAP: begin
              res_q <= 16'(wrap_q[col_q]);
              st_q  <= ST_PUT;
            end
            pps_pkg::K_SETWRAP: begin
              wrap_q[col_q] <= (data_q > 0);
              st_q          <= ST_IDLE;
            end
            pps_pkg::K_RDSTART: begin
              res_q <= 16'(start_q[col_q]);
              st_q  <= ST_PUT;
            end
            pps_pkg::K_SETSTART: begin
              start_q[col_q] <= nidx;
              st_q           <= ST_IDLE;
            end
            pps_pkg::K_RDEND: begin
              res_q <= 16'(end_q[col_q]);
              st_q  <= ST_PUT;
            end
            pps_pkg::K_SETEND: begin
              end_q[col_q] <= nidx;
              st_q         <= ST_IDLE;
            end
            // advance, then redo as a playhead access
            pps_pkg::K_NEXT: begin
              ph_q[col_q] <= nxt_ph;
              kind_q      <= pps_pkg::K_RDHERE;
              st_q        <= ST_EXEC;
            end
            pps_pkg::K_NEXTWR: begin
              ph_q[col_q] <= nxt_ph;
              kind_q      <= pps_pkg::K_WRHERE;
              st_q        <= ST_EXEC;
            end
            pps_pkg::K_NEXTALL: begin
              ph_q[col_q] <= nxt_ph;
              if (!last_col) begin
                col_q <= col_q + COL_W'(1);
                st_q  <= ST_EXEC;
              end else begin
                st_q  <= ST_IDLE;
              end
            end
            pps_pkg::K_STEP, pps_pkg::K_STEPFLAG, pps_pkg::K_STEPALL: st_q <= ST_STEP;
            pps_pkg::K_RDFLAG: begin
              res_q <= 16'(flag_q[col_q]);
              st_q  <= ST_PUT;
            end
            default: st_q <= ST_IDLE;
          endcase
        end
        ST_MEMRD: begin
          res_q <= ((kind_q == pps_pkg::K_RDVAL) || (kind_q == pps_pkg::K_RDHERE)) ?
                   val_rd : 16'(dur_rd);
          st_q  <= ST_PUT;
        end
        ST_STEP: begin
          // dur_rd holds the duration of the cell under the playhead
          if (cur_dwell == '0) begin
            dwell_q[col_q] <= DUR_W'(1);
            flag_q[col_q]  <= 1'b1;
          end else if ((17'(cur_dwell) + 17'd1) > 17'(dur_rd)) begin
            ph_q[col_q]    <= nxt_ph;
            dwell_q[col_q] <= DUR_W'(1);
            flag_q[col_q]  <= 1'b1;
          end else begin
            dwell_q[col_q] <= cur_dwell + DUR_W'(1);
            flag_q[col_q]  <= 1'b0;
          end
          case (kind_q)
            pps_pkg::K_STEP: begin
              kind_q <= pps_pkg::K_RDHERE;
              st_q   <= ST_EXEC;
            end
            pps_pkg::K_STEPFLAG: begin
              res_q <= 16'((cur_dwell == '0) ||
                           ((17'(cur_dwell) + 17'd1) > 17'(dur_rd)));
              st_q  <= ST_PUT;
            end
            default: begin
              if (!last_col) begin
                col_q <= col_q + COL_W'(1);
                st_q  <= ST_EXEC;
              end else begin
                st_q  <= ST_IDLE;
              end
            end
          endcase
        end
        ST_PUT: begin
          if (!out_vld_q || m_axis_tready) begin
            out_q     <= res_q;
            out_vld_q <= 1'b1;
            st_q      <= ST_IDLE;
          end
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

`ifndef SYNTHESIS
  a_acc_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> (st_q == ST_EXEC)) else $error("accepted word did not start");
  a_wr_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (val_we || dur_we) |-> (st_q == ST_EXEC)) else $error("stray cell write");
  a_out_put: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> ($past(st_q) == ST_PUT)) else $error("stray result word");
`endif

endmodule

`default_nettype wire

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: pattern_playhead_sequencer regression
// Drives directed and random command words, predicts each read word from a
// behavioral copy of the column state and compares results in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

  localparam int COLUMNS = pps_pkg::COLUMNS;
  localparam int CELLS   = pps_pkg::CELLS;
  localparam int NCELL   = COLUMNS * CELLS;

  // column state mirror and expected read words
  class seq_scoreboard;
    logic [15:0] vals [NCELL];
    int          durs [NCELL];
    int          ph [COLUMNS], dwell [COLUMNS], len [COLUMNS];
    int          lstart [COLUMNS], lend [COLUMNS];
    bit          flag [COLUMNS], wrap [COLUMNS];
    logic [15:0] pending [$];
    int          errors, checked;

    function void clear();
      for (int k = 0; k < NCELL; k++) begin
        vals[k] = '0;
        durs[k] = 1;
      end
      for (int k = 0; k < COLUMNS; k++) begin
        ph[k] = 0; dwell[k] = 0; flag[k] = 0; len[k] = 0;
        lstart[k] = 0; lend[k] = CELLS - 1; wrap[k] = 1;
      end
      pending.delete();
      errors = 0;
      checked = 0;
    endfunction

    function int fix_idx(int c, int i);
      if (i < 0) i = (i < -len[c]) ? 0 : len[c] + i;
      if (i >= CELLS) i = CELLS - 1;
      if (i < 0) i = 0;
      return i;
    endfunction

    function void move_on(int c);
      int p;
      p = ph[c];
      if (p == len[c] - 1 || p == lend[c]) begin
        if (wrap[c]) p = lstart[c];
      end else begin
        p++;
      end
      if (p > len[c] || p < 0 || p >= CELLS) p = 0;
      ph[c] = p;
    endfunction

    function void dwell_tick(int c);
      if (dwell[c] == 0) begin
        dwell[c] = 1; flag[c] = 1;
      end else if (dwell[c] + 1 > durs[c*CELLS+ph[c]]) begin
        move_on(c); dwell[c] = 1; flag[c] = 1;
      end else begin
        dwell[c]++; flag[c] = 0;
      end
    endfunction

    function void note_cmd(logic [4:0] kind, logic signed [15:0] col,
                           logic signed [15:0] idx, logic signed [15:0] dat);
      int c, i, d, r;
      bit has;
      c = (col < 0) ? 0 : (col >= COLUMNS) ? COLUMNS - 1 : int'(col);
      i = fix_idx(c, int'(idx));
      d = int'(dat);
      has = 1;
      r = 0;
      case (kind)
        pps_pkg::K_RDVAL:    r = vals[c*CELLS+i];
        pps_pkg::K_WRVAL:    begin vals[c*CELLS+i] = dat; has = 0; end
        pps_pkg::K_RDHERE:   r = vals[c*CELLS+ph[c]];
        pps_pkg::K_WRHERE:   begin vals[c*CELLS+ph[c]] = dat; has = 0; end
        pps_pkg::K_RDPH:     r = ph[c];
        pps_pkg::K_SETPH:    begin
          ph[c] = (len[c] == 0) ? 0 : (i >= len[c]) ? len[c] - 1 : i;
          dwell[c] = 0; has = 0;
        end
        pps_pkg::K_RDLEN:    r = len[c];
        pps_pkg::K_SETLEN:   begin
          len[c] = (d < 0) ? 0 : (d > CELLS) ? CELLS : d; has = 0;
        end
        pps_pkg::K_RDWRAP:   r = wrap[c];
        pps_pkg::K_SETWRAP:  begin wrap[c] = (d >= 1); has = 0; end
        pps_pkg::K_RDSTART:  r = lstart[c];
        pps_pkg::K_SETSTART: begin lstart[c] = i; has = 0; end
        pps_pkg::K_RDEND:    r = lend[c];
        pps_pkg::K_SETEND:   begin lend[c] = i; has = 0; end
        pps_pkg::K_NEXT:     begin move_on(c); r = vals[c*CELLS+ph[c]]; end
        pps_pkg::K_NEXTWR:   begin move_on(c); vals[c*CELLS+ph[c]] = dat; has = 0; end
        pps_pkg::K_NEXTALL:  begin
          for (int k = 0; k < COLUMNS; k++) move_on(k);
          has = 0;
        end
        pps_pkg::K_RDDUR:    r = durs[c*CELLS+i];
        pps_pkg::K_WRDUR:    begin durs[c*CELLS+i] = (d < 1) ? 1 : d; has = 0; end
        pps_pkg::K_RDDURH:   r = durs[c*CELLS+ph[c]];
        pps_pkg::K_WRDURH:   begin durs[c*CELLS+ph[c]] = (d < 1) ? 1 : d; has = 0; end
        pps_pkg::K_STEP:     begin dwell_tick(c); r = vals[c*CELLS+ph[c]]; end
        pps_pkg::K_RDFLAG:   r = flag[c];
        pps_pkg::K_STEPFLAG: begin dwell_tick(c); r = flag[c]; end
        pps_pkg::K_STEPALL:  begin
          for (int k = 0; k < COLUMNS; k++) dwell_tick(k);
          has = 0;
        end
        default:             has = 0;
      endcase
      if (has) pending.push_back(16'(r));
    endfunction

    function void check_word(logic [15:0] got);
      logic [15:0] want;
      if (pending.size() == 0) begin
        $error("read_word: none expected, actual %h", got);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got !== want) begin
        $error("read_word: expected %h, actual %h", want, got);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i, rst_ni;
  logic        s_axis_tvalid, s_axis_tready;
  logic [47:0] s_axis_tdata;   // column, cell_index, data_word
  logic [4:0]  s_axis_tuser;   // kind
  logic        m_axis_tvalid, m_axis_tready;
  logic [15:0] m_axis_tdata;   // read_word

  seq_scoreboard sb;
  int  idle_cycles = 0;
  int  sent;
  bit  hold_off;

  pattern_playhead_sequencer i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  initial begin
    clk_i = 0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [15:0] edgy16();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'hffff;
      3: return 16'(-$urandom_range(1, 70));
      default: return 16'($urandom_range(0, 70));
    endcase
  endfunction

  // one command word, held until accepted
  task automatic send_cmd(logic [4:0] kind, logic [15:0] col, logic [15:0] idx,
                          logic [15:0] dat);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {dat, idx, col};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_cmd(kind, col, idx, dat);
    sent++;
  endtask

  task automatic pause_cmd();
    s_axis_tvalid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk_i);
  endtask

  task automatic random_cmd();
    logic [4:0]  kind;
    logic [15:0] col, dat;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 3) kind = 5'($urandom_range(25, 31));
    else if (pick < 10) kind = 5'($urandom());
    else kind = 5'($urandom_range(0, 24));
    col = ($urandom_range(0, 9) == 0) ? 16'($urandom())
                                      : 16'($urandom_range(0, COLUMNS-1));
    dat = edgy16();
    if (kind == pps_pkg::K_WRVAL || kind == pps_pkg::K_WRHERE || kind == pps_pkg::K_NEXTWR)
      dat = 16'($urandom());
    if ((kind == pps_pkg::K_WRDUR || kind == pps_pkg::K_WRDURH) && $urandom_range(0, 3) != 0)
      dat = 16'($urandom_range(0, 4));
    send_cmd(kind, col, edgy16(), dat);
  endtask

  // receiver: random stall pattern, one long hold-off
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata);
    m_axis_tready <= hold_off ? 1'b0 : ($urandom_range(0, 3) != 0 || sent < 40);
  end

  initial begin
    hold_off = 0;
    wait (sent >= 300);
    hold_off = 1;
    repeat (400) @(posedge clk_i);
    hold_off = 0;
  end

  // watchdog: cycles with no handshake on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 3000) begin
      $display("pattern_playhead_sequencer regression: fail");
      $finish;
    end
  end

  initial begin
    logic [15:0] ext [4];
    sb = new();
    sb.clear();
    sent = 0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    m_axis_tready = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: reset values, clamps, negative indices, wrap, durations
    ext = '{16'h8000, 16'h7fff, 16'hffff, 16'h0000};
    send_cmd(pps_pkg::K_RDEND, 16'h0000, 16'd0, 16'd0);
    send_cmd(pps_pkg::K_RDWRAP, 16'h8000, 16'd0, 16'd0);
    send_cmd(pps_pkg::K_RDDUR, 16'h7fff, 16'h7fff, 16'd0);
    send_cmd(pps_pkg::K_SETLEN, 16'h0001, 16'd0, 16'h7fff);
    send_cmd(pps_pkg::K_RDLEN, 16'h0001, 16'd0, 16'd0);
    send_cmd(pps_pkg::K_SETLEN, 16'h0002, 16'd0, 16'h8000);
    send_cmd(pps_pkg::K_SETLEN, 16'h0000, 16'd0, 16'd5);
    for (int k = 0; k < 4; k++) send_cmd(pps_pkg::K_WRVAL, 16'd0, ext[k], ext[(k+1)%4]);
    send_cmd(pps_pkg::K_RDVAL, 16'd0, 16'hffff, 16'd0);
    send_cmd(pps_pkg::K_RDVAL, 16'd0, 16'h8000, 16'd0);
    send_cmd(pps_pkg::K_SETPH, 16'd0, 16'h7fff, 16'd0);
    send_cmd(pps_pkg::K_RDPH, 16'd0, 16'd0, 16'd0);
    send_cmd(pps_pkg::K_NEXT, 16'd0, 16'd0, 16'd0);
    send_cmd(pps_pkg::K_SETWRAP, 16'd0, 16'd0, 16'h8000);
    send_cmd(pps_pkg::K_NEXTWR, 16'd0, 16'd0, 16'h1234);
    send_cmd(pps_pkg::K_SETSTART, 16'd0, 16'hfffe, 16'd0);
    send_cmd(pps_pkg::K_SETEND, 16'd0, 16'd2, 16'd0);
    send_cmd(pps_pkg::K_WRDURH, 16'd0, 16'd0, 16'h8000);
    send_cmd(pps_pkg::K_WRDUR, 16'd0, 16'd1, 16'h7fff);
    send_cmd(pps_pkg::K_RDDURH, 16'd0, 16'd0, 16'd0);
    send_cmd(pps_pkg::K_STEPFLAG, 16'd0, 16'd0, 16'd0);
    send_cmd(pps_pkg::K_STEP, 16'd0, 16'd0, 16'd0);
    send_cmd(pps_pkg::K_NEXTALL, 16'd0, 16'd0, 16'd0);
    send_cmd(pps_pkg::K_STEPALL, 16'd0, 16'd0, 16'd0);
    send_cmd(pps_pkg::K_RDFLAG, 16'd0, 16'd0, 16'd0);
    send_cmd(pps_pkg::K_RDSTART, 16'd0, 16'd0, 16'd0);
    send_cmd(pps_pkg::K_RDHERE, 16'd0, 16'd0, 16'd0);
    send_cmd(pps_pkg::K_WRHERE, 16'd0, 16'd0, 16'hbeef);
    // random: bursts of commands with gaps between
    while (sent < 1600) begin
      repeat ($urandom_range(1, 20)) random_cmd();
      if ($urandom_range(0, 2) != 0) pause_cmd();
    end
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    $display("covered %0d command words, %0d read words checked across %0d columns",
             sent, sb.checked, COLUMNS);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("pattern_playhead_sequencer regression: pass");
    else
      $display("pattern_playhead_sequencer regression: fail");
    $finish;
  end

endmodule
